>>> rtl/core/ket_pkg.sv
// ket_pkg: shared types and constants for the keyed entry table
// request and status codes, field widths and the result struct
// no dependencies
`timescale 1ns / 1ps

package ket_pkg;

  localparam int KEY_W     = 32;
  localparam int CNT_W     = 6;
  localparam int NAME_MAX  = 64;
  localparam int REQ_W     = 2;
  localparam int STATUS_W  = 3;

  typedef enum logic [REQ_W-1:0] {
    REQ_ADD = 2'd0,
    REQ_DEL = 2'd1,
    REQ_GET = 2'd2,
    REQ_UPD = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_DUP     = 3'd2,
    ST_MISSING = 3'd3,
    ST_SAME    = 3'd4
  } status_e;

  typedef struct packed {
    status_e              status;
    logic [KEY_W-1:0]     key;
    logic [NAME_MAX-1:0]  name;
    logic [CNT_W-1:0]     count;
  } res_t;

endpackage

>>> rtl/core/ket_ram.sv
// ket_ram: generic single-write, single-read ram with registered read data
// used for the entry store of the keyed entry table
// no dependencies
`timescale 1ns / 1ps

module ket_ram #(
  parameter int  WIDTH = 96,
  parameter int  DEPTH = 32,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/ket_ctrl.sv
// ket_ctrl: request sequencer of the keyed entry table
// walks the entry ram one entry a cycle through a single key comparator
// depends on ket_pkg and ket_ram
`timescale 1ns / 1ps

module ket_ctrl #(
  parameter int DEPTH     = 32,
  parameter int NAME_BITS = 64
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  ket_pkg::req_e             req_type_i,
  input  logic [ket_pkg::KEY_W-1:0] key_i,
  input  logic [ket_pkg::KEY_W-1:0] new_key_i,
  input  logic [NAME_BITS-1:0]      name_i,
  input  logic [ket_pkg::CNT_W-1:0] capacity_i,
  input  logic                      res_free_i,
  output logic                      res_valid_o,
  output ket_pkg::res_t             res_o
);

  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EntW  = ket_pkg::KEY_W + NAME_BITS;
  localparam int CW    = ket_pkg::CNT_W;
  localparam int KW    = ket_pkg::KEY_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state_q, state_d;
  ket_pkg::req_e         req_q, req_d;
  logic [KW-1:0]         key_q, key_d;
  logic [KW-1:0]         nkey_q, nkey_d;
  logic [NAME_BITS-1:0]  name_q, name_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         idx_q, idx_d;
  logic [CW-1:0]         ridx_q, ridx_d;
  logic                  rv_q, rv_d;
  logic                  hit_q, hit_d;
  ket_pkg::status_e      st_q, st_d;
  logic [KW-1:0]         fkey_q, fkey_d;
  logic [NAME_BITS-1:0]  fname_q, fname_d;

  logic                  wr_en;
  logic [AddrW-1:0]      wr_addr;
  logic [EntW-1:0]       wr_data;
  logic [EntW-1:0]       rd_data;
  logic [KW-1:0]         rd_key;
  logic [NAME_BITS-1:0]  rd_name;
  logic                  issue;
  logic                  match;
  logic                  drained;

  ket_ram #(
    .WIDTH (EntW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data),
    .raddr_i (AddrW'(idx_q)),
    .rdata_o (rd_data)
  );

  assign rd_key  = rd_data[NAME_BITS +: KW];
  assign rd_name = rd_data[NAME_BITS-1:0];

  // the one shared comparator: stored key of the word read last cycle
  assign match   = rv_q && (rd_key == key_q);
  assign issue   = (idx_q < count_q);
  assign drained = !rv_q && !issue;

  assign req_ready_o = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE) && res_free_i;

  always_comb begin
    res_o.status = st_q;
    res_o.key    = fkey_q;
    res_o.name   = ket_pkg::NAME_MAX'(fname_q);
    res_o.count  = count_q;
  end

  always_comb begin
    state_d = state_q;
    req_d   = req_q;
    key_d   = key_q;
    nkey_d  = nkey_q;
    name_d  = name_q;
    count_d = count_q;
    idx_d   = idx_q;
    ridx_d  = ridx_q;
    rv_d    = 1'b0;
    hit_d   = hit_q;
    st_d    = st_q;
    fkey_d  = fkey_q;
    fname_d = fname_q;
    wr_en   = 1'b0;
    wr_addr = AddrW'(count_q);
    wr_data = {key_q, name_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          req_d   = req_type_i;
          key_d   = key_i;
          nkey_d  = new_key_i;
          name_d  = name_i;
          idx_d   = '0;
          hit_d   = 1'b0;
          fkey_d  = '0;
          fname_d = '0;
          st_d    = ket_pkg::ST_OK;
          if (req_type_i == ket_pkg::REQ_ADD && count_q >= capacity_i) begin
            st_d    = ket_pkg::ST_FULL;
            state_d = S_DONE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        if (issue) begin
          idx_d  = idx_q + 1'b1;
          ridx_d = idx_q;
          rv_d   = 1'b1;
        end
        if (match) begin
          unique case (req_q)
            ket_pkg::REQ_ADD: begin
              st_d    = ket_pkg::ST_DUP;
              rv_d    = 1'b0;
              state_d = S_DONE;
            end
            ket_pkg::REQ_DEL: begin
              // the read issued this cycle is the first word to move down
              state_d = S_SHIFT;
            end
            ket_pkg::REQ_GET: begin
              fkey_d  = rd_key;
              fname_d = rd_name;
              rv_d    = 1'b0;
              state_d = S_DONE;
            end
            ket_pkg::REQ_UPD: begin
              if (nkey_q == key_q) begin
                st_d    = ket_pkg::ST_SAME;
                rv_d    = 1'b0;
                state_d = S_DONE;
              end else begin
                wr_en   = 1'b1;
                wr_addr = AddrW'(ridx_q);
                wr_data = {nkey_q, name_q};
                hit_d   = 1'b1;
              end
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end else if (drained) begin
          state_d = S_DONE;
          unique case (req_q)
            ket_pkg::REQ_ADD: begin
              wr_en   = 1'b1;
              wr_addr = AddrW'(count_q);
              wr_data = {key_q, name_q};
              count_d = count_q + 1'b1;
            end
            ket_pkg::REQ_UPD: begin
              st_d = hit_q ? ket_pkg::ST_OK : ket_pkg::ST_MISSING;
            end
            default: begin
              st_d = ket_pkg::ST_MISSING;
            end
          endcase
        end
      end

      S_SHIFT: begin
        if (issue) begin
          idx_d  = idx_q + 1'b1;
          ridx_d = idx_q;
          rv_d   = 1'b1;
        end
        if (rv_q) begin
          wr_en   = 1'b1;
          wr_addr = AddrW'(ridx_q - 1'b1);
          wr_data = rd_data;
        end
        if (drained) begin
          count_d = count_q - 1'b1;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (res_free_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      ridx_q  <= '0;
      rv_q    <= 1'b0;
      hit_q   <= 1'b0;
      st_q    <= ket_pkg::ST_OK;
      req_q   <= ket_pkg::REQ_ADD;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      ridx_q  <= ridx_d;
      rv_q    <= rv_d;
      hit_q   <= hit_d;
      st_q    <= st_d;
      req_q   <= req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    nkey_q  <= nkey_d;
    name_q  <= name_d;
    fkey_q  <= fkey_d;
    fname_q <= fname_d;
  end

endmodule

>>> rtl/core/keyed_entry_table_top.sv
// keyed_entry_table_top: keyed entry table with stream ports and a capacity register
// holds the capacity register and the output word register
// depends on ket_pkg, ket_ctrl and ket_ram
`timescale 1ns / 1ps

// Keyed entry table: up to DEPTH entries of an unsigned 32-bit key and a packed
// name, kept in insertion order. Each request word on the s_axis channel
// (add, delete, get or update by key) yields exactly one result word on the
// m_axis channel with a status, the key and name found by a get, and the
// entry count after the request.
// The capacity register is written via cfg_we_i / cfg_wdata_i, by the user only
// while the table is idle (the block does not enforce this); values above
// min(DEPTH, 63) saturate to that value. The sequencer walks the stored
// entries one per cycle through a single ram read port and one key
// comparator; a get or a duplicate add stops at the first match, a delete
// moves the following entries down one per cycle, and an add to a full
// table skips the walk.
// s_axis_tready is low while a request is being worked on.
// The result sits in an output register: the next request is taken while a
// result still waits, and a stalled receiver holds the sequencer only when
// a second result is ready. Reset empties the table and sets capacity to
// the smaller of 32 and DEPTH; no clearing pass is needed.

module keyed_entry_table_top #(
  parameter int DEPTH     = 32,
  parameter int NAME_BITS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // req_type[1:0], key[33:2], new_key[65:34], entry_name[129:66], zero pad
  input  logic [135:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], found_key[34:3], found_name[98:35], entry_count[104:99], zero pad
  output logic [111:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [5:0]   cfg_wdata_i
);

  localparam int CW = ket_pkg::CNT_W;
  localparam int CapMax = (DEPTH > 63) ? 63 : DEPTH;
  localparam int CapRst = (DEPTH > 32) ? 32 : DEPTH;

  logic [CW-1:0]  cap_q;
  logic           mvalid_q;
  ket_pkg::res_t  mres_q;
  ket_pkg::res_t  res;
  logic           res_valid;
  logic           res_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(CapRst);
    end else if (cfg_we_i) begin
      cap_q <= (cfg_wdata_i > CW'(CapMax)) ? CW'(CapMax) : cfg_wdata_i;
    end
  end

  assign res_free = !mvalid_q || m_axis_tready;

  ket_ctrl #(
    .DEPTH     (DEPTH),
    .NAME_BITS (NAME_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_type_i  (ket_pkg::req_e'(s_axis_tdata[1:0])),
    .key_i       (s_axis_tdata[33:2]),
    .new_key_i   (s_axis_tdata[65:34]),
    .name_i      (s_axis_tdata[66 +: NAME_BITS]),
    .capacity_i  (cap_q),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else if (res_valid) begin
      mvalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      mres_q <= res;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {7'd0, mres_q.count, mres_q.name, mres_q.key, mres_q.status};

endmodule
